### rtl/core/rmf_pkg.sv
// Package for the running median filter.
// Holds field widths, reset values and the rank unit control struct.
// No dependencies.
package rmf_pkg;

  localparam int unsigned DATA_W         = 8;
  localparam int unsigned AGE_W          = 8;
  localparam int unsigned ENTRY_W        = AGE_W + DATA_W;
  localparam int unsigned CFG_W          = 4;
  localparam int unsigned MAX_WINDOW_DEF = 15;
  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(1);

  typedef struct packed {
    logic load;
    logic clear;
    logic step;
  } rank_ctl_t;

endpackage

### rtl/core/rmf_slot_mem.sv
// Slot store of the running median filter: {age, value} per slot.
// One write port, one registered read port, per-entry valid bits for reset.
// Depends on rmf_pkg.
module rmf_slot_mem import rmf_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int unsigned AW         = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [ENTRY_W-1:0] wdata_i,
  output logic [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0]    mem_q [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] vld_q;
  logic [ENTRY_W-1:0]    rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

### rtl/core/rmf_rank_sel.sv
// Rank selection unit of the running median filter.
// Keeps a copy of the window values, counts a stable rank per slot and
// returns the value whose rank equals the requested rank sel_i. Depends on rmf_pkg.
module rmf_rank_sel import rmf_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int unsigned AW         = 4,
  parameter int unsigned CW         = 4
) (
  input  logic              clk_i,
  input  rank_ctl_t         ctl_i,
  input  logic [AW-1:0]     idx_i,
  input  logic [DATA_W-1:0] val_i,
  input  logic [CW-1:0]     win_i,
  input  logic [CW-1:0]     sel_i,
  output logic [DATA_W-1:0] pick_o
);

  logic [DATA_W-1:0] c_q [MAX_WINDOW];
  logic [CW-1:0]     r_q [MAX_WINDOW];
  logic [DATA_W-1:0] cj;

  assign cj = c_q[idx_i];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      c_q[idx_i] <= val_i;
    end
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (ctl_i.clear) begin
        r_q[i] <= '0;
      end else if (ctl_i.step &&
                   ((cj < c_q[i]) || ((cj == c_q[i]) && (idx_i < AW'(i))))) begin
        r_q[i] <= r_q[i] + CW'(1);
      end
    end
  end

  always_comb begin
    pick_o = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if ((CW'(i) < win_i) && (r_q[i] == sel_i)) begin
        pick_o = c_q[i];
      end
    end
  end

endmodule

### rtl/core/running_median_filter.sv
// Top level of the running median filter.
// Depends on rmf_pkg, rmf_slot_mem and rmf_rank_sel.
//
// Usage:
//   Input channel: sample_i with in_valid_i / in_stall_o. A transaction
//   takes place at a clock edge with valid high and stall low.
//   Output channel: median_o with out_valid_o / out_stall_i, same rule.
//   Configuration: cfg_we_i writes cfg_wdata_i into the window size
//   register; write it only while no sample is in flight.
//   Each sample runs through these steps over the effective window
//   (1 .. MAX_WINDOW slots): one pass over the slot memory to age the
//   slots, copy their values into the rank unit and find the oldest, one
//   write of the new sample into the oldest slot, one pass over the window
//   to rank the values, and a select step. One sample is in work at a
//   time; a new sample is taken once the previous result sits in the
//   output register.
//   Reset clears the window size to 1 and all slots to value and age zero.
//   While the receiver stalls, the result is held; a finished sample waits
//   in the select cycle until the output register frees.
module running_median_filter import rmf_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DATA_W-1:0] sample_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] median_o
);

  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WW = (CW > CFG_W) ? CW : CFG_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_VICT = 3'd2;
  localparam logic [2:0] S_RANK = 3'd3;
  localparam logic [2:0] S_PICK = 3'd4;

  logic [CFG_W-1:0]  win_size_q;
  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     cnt_inc;
  logic [AGE_W-1:0]  top_q, top_d;
  logic [AW-1:0]     vict_q, vict_d;
  logic [DATA_W-1:0] sample_q, sample_d;
  logic [DATA_W-1:0] med_q, med_d;
  logic              ovld_q, ovld_d;

  logic [WW-1:0]     ws_ext;
  logic [WW-1:0]     max_ext;
  logic [WW-1:0]     win_ext;
  logic [CW-1:0]     win;
  logic [CW-1:0]     last;
  logic [CW-1:0]     sel;

  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;
  logic [AGE_W-1:0]  rd_age;
  logic [DATA_W-1:0] rd_val;
  logic [AGE_W-1:0]  age_inc;

  rank_ctl_t         rctl;
  logic [AW-1:0]     r_idx;
  logic [DATA_W-1:0] r_val;
  logic [DATA_W-1:0] pick;

  assign ws_ext  = WW'(win_size_q);
  assign max_ext = WW'(MAX_WINDOW);
  assign win_ext = (ws_ext == '0) ? WW'(1) : ((ws_ext > max_ext) ? max_ext : ws_ext);
  assign win     = CW'(win_ext);
  assign last    = win - CW'(1);
  assign sel     = win >> 1;
  assign cnt_inc = cnt_q + CW'(1);

  assign rd_age  = mem_rdata[ENTRY_W-1:DATA_W];
  assign rd_val  = mem_rdata[DATA_W-1:0];
  assign age_inc = rd_age + AGE_W'(1);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    top_d     = top_q;
    vict_d    = vict_q;
    sample_d  = sample_q;
    med_d     = med_q;
    ovld_d    = ovld_q & out_stall_i;
    mem_re    = 1'b0;
    mem_raddr = cnt_q[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_wdata = {age_inc, rd_val};
    rctl      = '0;
    r_idx     = cnt_q[AW-1:0];
    r_val     = rd_val;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sample_d  = sample_i;
          cnt_d     = '0;
          top_d     = '0;
          vict_d    = '0;
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        mem_we    = 1'b1;
        rctl.load = 1'b1;
        if (age_inc > top_q) begin
          top_d  = age_inc;
          vict_d = cnt_q[AW-1:0];
        end
        if (cnt_q == last) begin
          state_d = S_VICT;
        end else begin
          cnt_d     = cnt_inc;
          mem_re    = 1'b1;
          mem_raddr = cnt_inc[AW-1:0];
        end
      end
      S_VICT: begin
        mem_we     = 1'b1;
        mem_waddr  = vict_q;
        mem_wdata  = {AGE_W'(0), sample_q};
        rctl.load  = 1'b1;
        rctl.clear = 1'b1;
        r_idx      = vict_q;
        r_val      = sample_q;
        cnt_d      = '0;
        state_d    = S_RANK;
      end
      S_RANK: begin
        rctl.step = 1'b1;
        if (cnt_q == last) begin
          state_d = S_PICK;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      S_PICK: begin
        if (!(ovld_q && out_stall_i)) begin
          med_d   = pick;
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= WINDOW_RESET;
      state_q    <= S_IDLE;
      ovld_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_size_q <= cfg_wdata_i;
      end
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    top_q    <= top_d;
    vict_q   <= vict_d;
    sample_q <= sample_d;
    med_q    <= med_d;
  end

  rmf_slot_mem #(
    .MAX_WINDOW(MAX_WINDOW),
    .AW        (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  rmf_rank_sel #(
    .MAX_WINDOW(MAX_WINDOW),
    .AW        (AW),
    .CW        (CW)
  ) u_rank (
    .clk_i (clk_i),
    .ctl_i (rctl),
    .idx_i (r_idx),
    .val_i (r_val),
    .win_i (win),
    .sel_i (sel),
    .pick_o(pick)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ovld_q;
  assign median_o    = med_q;

endmodule
